[hw/rtl/wbps_pkg.sv]
// shared types, codes and helpers for the wildcard byte pattern scanner
package wbps_pkg;

	localparam int DEF_MAX_PATTERN = 64;
	localparam int ADDR_W          = 64;
	localparam int OFFSET_W        = 32;
	localparam int BYTE_W          = 8;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_CHAR  = 2'd1,
		ACT_BYTE  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_NOT_FOUND   = 2'd0,
		ST_FOUND       = 2'd1,
		ST_BAD_PATTERN = 2'd2
	} status_t;

	typedef enum logic {
		REG_REGION_START  = 1'b0,
		REG_RESULT_OFFSET = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		PH_FIRST = 3'd0,
		PH_WILD  = 3'd1,
		PH_HEX2  = 3'd2,
		PH_SEP   = 3'd3,
		PH_STOP  = 3'd4
	} phase_t;

	// command from the scanner to the signature parser
	typedef struct packed {
		logic              clear;
		logic              put;
		logic              last;
		logic [BYTE_W-1:0] ch;
	} pat_cmd_t;

	localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
	localparam logic [BYTE_W-1:0] CH_WILD    = 8'h3F;
	localparam logic [BYTE_W-1:0] CH_DIGIT_0 = 8'h30;
	localparam logic [BYTE_W-1:0] CH_DIGIT_9 = 8'h39;
	localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UPPER_F = 8'h46;
	localparam logic [3:0]        HEX_ALPHA_BASE = 4'hA;

	// {valid, nibble}; only '0'-'9' and 'A'-'F' count as digits
	function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
		logic [4:0] r;
		r = '0;
		if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
			r = {1'b1, 4'(c - CH_DIGIT_0)};
		end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
			r = {1'b1, 4'(c - CH_UPPER_A) + HEX_ALPHA_BASE};
		end
		return r;
	endfunction

endpackage

[hw/rtl/wbps_in_if.sv]
// input channel of the scanner: action, character or region byte, last flag
interface wbps_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data_value;
	logic       final_item;

	modport source (output valid, action, data_value, final_item, input ready);
	modport sink (input valid, action, data_value, final_item, output ready);
endinterface

[hw/rtl/wbps_out_if.sv]
// result channel of the scanner: status and match address
interface wbps_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] match_address;

	modport source (output valid, status, match_address, input ready);
	modport sink (input valid, status, match_address, output ready);
endinterface

[hw/rtl/wbps_parser.sv]
// signature text parser holding the pattern, newest entry at index zero
module wbps_parser #(
	parameter int MAX_PATTERN = wbps_pkg::DEF_MAX_PATTERN,
	localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  wbps_pkg::pat_cmd_t                        cmd,
	output logic [MAX_PATTERN-1:0][wbps_pkg::BYTE_W-1:0] pat_bytes,
	output logic [MAX_PATTERN-1:0]                    pat_care,
	output logic [LEN_W-1:0]                          pat_len,
	output logic                                      too_long
);
	import wbps_pkg::*;

	phase_t                 phase_q, phase_n;
	logic [3:0]             held_q, held_n;
	logic [LEN_W-1:0]       len_q;
	logic                   too_long_q;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] bytes_q;
	logic [MAX_PATTERN-1:0] care_q;
	logic                   add;
	logic [BYTE_W-1:0]      add_val;
	logic                   add_care;
	logic [4:0]             hex;

	always_comb begin
		hex      = hex_decode(cmd.ch);
		phase_n  = phase_q;
		held_n   = held_q;
		add      = 1'b0;
		add_val  = '0;
		add_care = 1'b0;
		case (phase_q)
			PH_FIRST: begin
				if (cmd.ch == CH_WILD) begin
					phase_n = PH_WILD;
				end else if (hex[4]) begin
					held_n  = hex[3:0];
					phase_n = PH_HEX2;
				end else begin
					phase_n = PH_STOP;
				end
			end
			PH_WILD: begin
				if (cmd.ch != CH_NUL) begin
					add     = 1'b1;
					phase_n = PH_FIRST;
				end else begin
					phase_n = PH_STOP;
				end
			end
			PH_HEX2: begin
				if (hex[4]) begin
					add      = 1'b1;
					add_val  = {held_q, hex[3:0]};
					add_care = 1'b1;
					phase_n  = PH_SEP;
				end else begin
					phase_n = PH_STOP;
				end
			end
			PH_SEP: begin
				phase_n = (cmd.ch != CH_NUL) ? PH_FIRST : PH_STOP;
			end
			default: begin
				phase_n = PH_STOP;
			end
		endcase
		// text ends on the last character
		if (cmd.last) begin
			phase_n = PH_STOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FIRST;
			held_q     <= '0;
			len_q      <= '0;
			too_long_q <= 1'b0;
		end else if (cmd.clear) begin
			phase_q    <= PH_FIRST;
			held_q     <= '0;
			len_q      <= '0;
			too_long_q <= 1'b0;
		end else if (cmd.put) begin
			phase_q <= phase_n;
			held_q  <= held_n;
			if (add) begin
				if (len_q < LEN_W'(MAX_PATTERN)) begin
					len_q <= len_q + LEN_W'(1);
				end else begin
					too_long_q <= 1'b1;
				end
			end
		end
	end

	// entries shift up as new ones arrive, so index j meets window byte j
	always_ff @(posedge clk) begin
		if (!cmd.clear && cmd.put && add && len_q < LEN_W'(MAX_PATTERN)) begin
			bytes_q[0] <= add_val;
			care_q[0]  <= add_care;
			for (int j = 1; j < MAX_PATTERN; j++) begin
				bytes_q[j] <= bytes_q[j-1];
				care_q[j]  <= care_q[j-1];
			end
		end
	end

	assign pat_bytes = bytes_q;
	assign pat_care  = care_q;
	assign pat_len   = len_q;
	assign too_long  = too_long_q;

endmodule

[hw/rtl/wildcard_byte_pattern_scanner.sv]
// top level of the wildcard byte pattern scanner
//
// usage:
// - item channel: action clear drops the pattern, action char feeds one
//   signature character, action byte feeds one region byte; final_item marks
//   the last character of the text or the last byte of the region
// - result channel: one transaction on the first matching window (status
//   found, address = region_start + window position + result_offset), or one
//   on the last region byte without a match (not found, or bad pattern when
//   the pattern is empty or too long; address zero)
// - config: write_en/write_index/write_data, index 0 region_start,
//   index 1 result_offset, written while the block is idle
// path: an item taken into the stage-one register has its result registered
//   in the result register once that register is free
// throughput: one item per cycle while not stalled; the window compare is one
//   parallel bank of MAX_PATTERN byte comparators on the stage-one register
// reset: empty pattern, parser at first symbol, region counters at zero
// stall: the result register holds while it is full and result.ready is low;
//   the stage-one register then holds and item.ready drops once it is full
// the running address counter reloads via the registered write strobe unless a byte fires
module wildcard_byte_pattern_scanner #(
	parameter int MAX_PATTERN = wbps_pkg::DEF_MAX_PATTERN
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          write_en,
	input  logic          write_index,
	input  logic [63:0]   write_data,
	wbps_in_if.sink       item,
	wbps_out_if.source    result
);
	import wbps_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	// stage one: registered input transaction
	logic              valid_s1;
	logic [1:0]        action_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              last_s1;

	// config and address tracking
	logic [ADDR_W-1:0]   start_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [ADDR_W-1:0]   base_q;     // region_start + result_offset
	logic [ADDR_W-1:0]   cur_q;      // base + bytes seen so far
	logic [ADDR_W-1:0]   seen_q;
	logic                reload_q;

	// scan state
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_q, win_next;
	logic [LEN_W-1:0]    fill_q, fill_next;
	logic                finished_q;

	// pattern from the parser
	pat_cmd_t            cmd;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_bytes;
	logic [MAX_PATTERN-1:0] pat_care;
	logic [LEN_W-1:0]    pat_len;
	logic                too_long;

	// result register
	logic                res_valid_q;
	status_t             res_status_q;
	logic [ADDR_W-1:0]   res_addr_q;

	logic                out_free;
	logic                fire_s1;
	logic                byte_fire;
	logic [MAX_PATTERN-1:0] hit;
	logic                match;
	logic                produce;
	status_t             status_n;
	logic [ADDR_W-1:0]   addr_n;

	// item moves on when the result register is empty or being drained
	assign out_free   = !res_valid_q || result.ready;
	assign fire_s1    = valid_s1 && out_free;
	assign item.ready = !valid_s1 || fire_s1;
	assign byte_fire  = fire_s1 && (action_s1 == ACT_BYTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			action_s1 <= item.action;
			data_s1   <= item.data_value;
			last_s1   <= item.final_item;
		end
	end

	// config registers; base sum kept so a match needs only one subtract
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			offset_q <= '0;
			base_q   <= '0;
			reload_q <= 1'b0;
		end else begin
			reload_q <= write_en;
			if (write_en) begin
				case (write_index)
					REG_REGION_START: begin
						start_q <= write_data;
						base_q  <= write_data + ADDR_W'(offset_q);
					end
					REG_RESULT_OFFSET: begin
						offset_q <= write_data[OFFSET_W-1:0];
						base_q   <= start_q + ADDR_W'(write_data[OFFSET_W-1:0]);
					end
					default: begin
						base_q <= base_q;
					end
				endcase
			end
		end
	end

	always_comb begin
		cmd.clear = fire_s1 && (action_s1 == ACT_CLEAR);
		cmd.put   = fire_s1 && (action_s1 == ACT_CHAR);
		cmd.last  = last_s1;
		cmd.ch    = data_s1;
	end

	wbps_parser #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.pat_bytes (pat_bytes),
		.pat_care  (pat_care),
		.pat_len   (pat_len),
		.too_long  (too_long)
	);

	// window with the incoming byte at index zero, oldest at the top
	always_comb begin
		win_next[0] = data_s1;
		for (int j = 1; j < MAX_PATTERN; j++) begin
			win_next[j] = win_q[j-1];
		end
		fill_next = (fill_q < LEN_W'(MAX_PATTERN)) ? fill_q + LEN_W'(1) : fill_q;
	end

	// parallel compare: pattern entry j lines up with window byte j
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			hit[j] = (LEN_W'(j) >= pat_len) || !pat_care[j] ||
				(win_next[j] == pat_bytes[j]);
		end
	end

	always_comb begin
		match = (&hit) && (pat_len != '0) && !too_long && (fill_next >= pat_len) &&
			!finished_q;
		produce = byte_fire && (match || (last_s1 && !finished_q));
		if (match) begin
			status_n = ST_FOUND;
			addr_n   = cur_q + ADDR_W'(1) - ADDR_W'(pat_len);
		end else begin
			status_n = (pat_len == '0 || too_long) ? ST_BAD_PATTERN : ST_NOT_FOUND;
			addr_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			finished_q <= 1'b0;
			seen_q     <= '0;
			cur_q      <= '0;
		end else if (byte_fire) begin
			if (last_s1) begin
				// last byte starts a new region
				fill_q     <= '0;
				finished_q <= 1'b0;
				seen_q     <= '0;
				cur_q      <= base_q;
			end else begin
				fill_q <= fill_next;
				seen_q <= seen_q + ADDR_W'(1);
				cur_q  <= cur_q + ADDR_W'(1);
				if (match) begin
					finished_q <= 1'b1;
				end
			end
		end else if (reload_q) begin
			cur_q <= base_q + seen_q;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_fire) begin
			win_q <= win_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= produce;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			res_status_q <= status_n;
			res_addr_q   <= addr_n;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.status        = res_status_q;
	assign result.match_address = res_addr_q;

	// pattern and clear transactions never leave a result behind
	a_no_result_from_text: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && action_s1 != ACT_BYTE |=> !res_valid_q)
		else $error("result raised by a non-byte transaction");

	// a match closes the region until its last byte
	a_match_closes: assert property (@(posedge clk) disable iff (!arst_n)
		byte_fire && match && !last_s1 |=> finished_q)
		else $error("scan not closed after a match");

	// last byte resets the region counters
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		byte_fire && last_s1 |=> fill_q == '0 && !finished_q && seen_q == '0)
		else $error("region not restarted after its last byte");

	// only a found result carries an address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_status_q != ST_FOUND |-> res_addr_q == '0)
		else $error("address on a result that is not found");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LEN_W'(MAX_PATTERN))
		else $error("window fill count past depth");

endmodule

[verif/wildcard_byte_pattern_scanner_tb.sv]
// self-checking testbench for the wildcard byte pattern scanner
module wildcard_byte_pattern_scanner_tb;

	import wbps_pkg::*;

	localparam int          DEPTH         = DEF_MAX_PATTERN;
	localparam int          RANDOM_ITEMS  = 600;
	localparam int          PHASE_ITEMS   = 60;
	localparam int          MAX_WAIT      = 6;
	localparam int          HOLD_CYCLES   = 60;
	localparam int          DRAIN_CYCLES  = 6;
	localparam int          QUIET_LIMIT   = 2000;
	localparam logic [1:0]  ACT_UNUSED    = 2'd3;
	localparam logic [7:0]  CH_SEPARATOR  = 8'h20;
	localparam logic [7:0]  CH_LOWER_A    = 8'h61;

	// one input transaction
	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_value;
		logic       final_item;
	} scan_item_t;

	// one result transaction
	typedef struct {
		status_t     status;
		logic [63:0] match_address;
	} scan_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        write_en;
	logic        write_index;
	logic [63:0] write_data;

	wbps_in_if  item_ch ();
	wbps_out_if result_ch ();

	wildcard_byte_pattern_scanner i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.write_en    (write_en),
		.write_index (write_index),
		.write_data  (write_data),
		.item        (item_ch),
		.result      (result_ch)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// scanner state as the testbench sees it
	// ------------------------------------------------------------------
	logic [63:0] cfg_region_start  = '0;
	logic [31:0] cfg_result_offset = '0;
	logic [7:0]  sig_bytes [DEPTH];
	bit          sig_care  [DEPTH];
	int          sig_len       = 0;
	bit          sig_overflow  = 1'b0;
	phase_t      parse_state   = PH_FIRST;
	logic [3:0]  held_nibble   = '0;
	logic [7:0]  window_mem [DEPTH];
	int          window_head   = 0;
	int          window_fill   = 0;
	logic [63:0] region_count  = '0;
	bit          region_done   = 1'b0;

	scan_item_t   pending_items [$];
	scan_result_t expected_results [$];

	// run control shared between the stimulus and the two handshake processes
	bit sender_burst      = 1'b0;
	bit receiver_burst    = 1'b0;
	int holds_requested   = 0;
	int mismatch_count    = 0;
	int random_items      = 0;
	bit count_random      = 1'b0;
	bit region_open       = 1'b0;
	int scenario_index    = 0;

	// pattern that the generator last built, used to plant hits in a region
	logic [7:0] gen_bytes [$];
	bit         gen_care  [$];

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// only '0'-'9' and 'A'-'F' are digits; lowercase stops the parse
	function automatic bit decode_hex(input logic [7:0] c, output logic [3:0] nib);
		nib = '0;
		if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
			nib = 4'(c - CH_DIGIT_0);
			return 1'b1;
		end
		if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
			nib = 4'(c - CH_UPPER_A) + HEX_ALPHA_BASE;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// entries past the pattern limit are dropped and flag the pattern
	task automatic add_sig_entry(input logic [7:0] value, input bit care);
		if (sig_len < DEPTH) begin
			sig_bytes[sig_len] = value;
			sig_care[sig_len]  = care;
			sig_len++;
		end else begin
			sig_overflow = 1'b1;
		end
	endtask

	// compare the newest sig_len window bytes against the cared entries
	function automatic bit window_hit();
		int start_pos;
		start_pos = (window_head + DEPTH - sig_len) % DEPTH;
		for (int i = 0; i < sig_len; i++) begin
			if (sig_care[i] && window_mem[(start_pos + i) % DEPTH] != sig_bytes[i])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// advance the scanner state by one accepted transaction and queue its result
	task automatic predict_item(input logic [1:0] act, input logic [7:0] dv, input logic fin);
		logic [3:0]   nib;
		scan_result_t res;
		case (act)
			ACT_CLEAR: begin
				// clear touches the pattern and parser only, never the scan
				sig_len      = 0;
				sig_overflow = 1'b0;
				parse_state  = PH_FIRST;
				held_nibble  = '0;
			end
			ACT_CHAR: begin
				case (parse_state)
					PH_FIRST: begin
						if (dv == CH_WILD) begin
							parse_state = PH_WILD;
						end else if (decode_hex(dv, nib)) begin
							held_nibble = nib;
							parse_state = PH_HEX2;
						end else begin
							parse_state = PH_STOP;
						end
					end
					PH_WILD: begin
						if (dv != CH_NUL) begin
							add_sig_entry(8'h00, 1'b0);
							parse_state = PH_FIRST;
						end else begin
							parse_state = PH_STOP;
						end
					end
					PH_HEX2: begin
						if (decode_hex(dv, nib)) begin
							add_sig_entry({held_nibble, nib}, 1'b1);
							parse_state = PH_SEP;
						end else begin
							parse_state = PH_STOP;
						end
					end
					PH_SEP: begin
						parse_state = (dv != CH_NUL) ? PH_FIRST : PH_STOP;
					end
					default: begin
						parse_state = PH_STOP;
					end
				endcase
				// text ends on its final character whatever the parser was doing
				if (fin)
					parse_state = PH_STOP;
			end
			ACT_BYTE: begin
				window_mem[window_head] = dv;
				window_head = (window_head + 1) % DEPTH;
				if (window_fill < DEPTH)
					window_fill++;
				region_count++;
				if (!region_done && sig_len > 0 && !sig_overflow && window_fill >= sig_len
						&& window_hit()) begin
					region_done = 1'b1;
					res.status = ST_FOUND;
					res.match_address = cfg_region_start + (region_count - 64'(sig_len))
						+ {32'h0, cfg_result_offset};
					expected_results.push_back(res);
				end else if (fin && !region_done) begin
					if (sig_len == 0 || sig_overflow)
						res.status = ST_BAD_PATTERN;
					else
						res.status = ST_NOT_FOUND;
					res.match_address = '0;
					expected_results.push_back(res);
				end
				// last byte opens a new region
				if (fin) begin
					region_count = '0;
					window_fill  = 0;
					region_done  = 1'b0;
				end
			end
			default: begin
				// unused action code, nothing happens
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// driver: feeds pending transactions with a random gap before each
	// ------------------------------------------------------------------
	int send_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid      <= 1'b0;
			item_ch.action     <= ACT_CLEAR;
			item_ch.data_value <= '0;
			item_ch.final_item <= 1'b0;
			send_gap           <= 0;
		end else begin
			scan_item_t nxt_item;
			if (item_ch.valid && item_ch.ready)
				predict_item(item_ch.action, item_ch.data_value, item_ch.final_item);
			// the slot is free when nothing is offered or the offer was taken
			if (!item_ch.valid || item_ch.ready) begin
				if (send_gap > 0) begin
					send_gap      <= send_gap - 1;
					item_ch.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					nxt_item = pending_items.pop_front();
					item_ch.valid      <= 1'b1;
					item_ch.action     <= nxt_item.action;
					item_ch.data_value <= nxt_item.data_value;
					item_ch.final_item <= nxt_item.final_item;
					send_gap <= sender_burst ? 0 : $urandom_range(0, MAX_WAIT);
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: checks each result, may stall after each one, long hold on request
	// ------------------------------------------------------------------
	int stall_left;
	int hold_left;
	int holds_served;

	task automatic check_result(input logic [1:0] st, input logic [63:0] addr);
		scan_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result status %0d address %h", st, addr));
		end else begin
			want = expected_results.pop_front();
			if (st !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
			if (addr !== want.match_address)
				report_mismatch($sformatf("match address %h, expected %h",
					addr, want.match_address));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left      <= 0;
			hold_left       <= 0;
			holds_served    <= 0;
		end else begin
			int stall;
			if (result_ch.valid && result_ch.ready)
				check_result(result_ch.status, result_ch.match_address);
			if (holds_served != holds_requested) begin
				// long back-pressure so the block fills up and drops item ready
				holds_served    <= holds_requested;
				hold_left       <= HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left       <= hold_left - 1;
				result_ch.ready <= 1'b0;
			end else if (result_ch.valid && result_ch.ready) begin
				stall = receiver_burst ? 0 : $urandom_range(0, MAX_WAIT);
				if (stall == 0) begin
					result_ch.ready <= 1'b1;
				end else begin
					result_ch.ready <= 1'b0;
					stall_left      <= stall - 1;
				end
			end else if (stall_left > 0) begin
				stall_left      <= stall_left - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too long without any transaction or register write
	// ------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
					|| write_en) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				report_mismatch($sformatf("no transaction for %0d cycles, %0d results missing",
					QUIET_LIMIT, expected_results.size()));
				$display("** wildcard_byte_pattern_scanner: FAILED **");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_item(input logic [1:0] act, input logic [7:0] dv, input logic fin);
		pending_items.push_back('{act, dv, fin});
		if (act == ACT_BYTE)
			region_open = !fin;
		if (count_random && act != ACT_UNUSED)
			random_items++;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < HEX_ALPHA_BASE)
			return CH_DIGIT_0 + 8'(nib);
		return CH_UPPER_A + 8'(nib - HEX_ALPHA_BASE);
	endfunction

	// small alphabet most of the time so unplanted windows hit too
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h3F;
			3: return 8'h5A;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [63:0] pick_config(input int bits);
		logic [63:0] v;
		case ($urandom_range(0, 3))
			0: v = '0;
			1: v = '1;
			default: v = {$urandom, $urandom};
		endcase
		// upper half of the offset write carries junk that must be dropped
		if (bits == OFFSET_W && v != '0 && v != '1)
			v[63:32] = $urandom;
		return v;
	endfunction

	// register write while the block is idle
	task automatic write_register(input reg_index_t idx, input logic [63:0] value);
		@(posedge clk);
		write_en    <= 1'b1;
		write_index <= idx;
		write_data  <= value;
		@(posedge clk);
		write_en <= 1'b0;
		case (idx)
			REG_REGION_START:  cfg_region_start  = value;
			REG_RESULT_OFFSET: cfg_result_offset = value[31:0];
			default: ;
		endcase
	endtask

	// sender pause: everything sent, every result back, then latency slack
	task automatic settle_pipeline();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// signature text with n_entries entries and a randomly chosen tail
	task automatic push_pattern(input int n_entries, input bit do_clear);
		int         ending;
		bit         tail_final;
		bit         wild;
		logic [7:0] v;
		if (do_clear)
			push_item(ACT_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		gen_bytes.delete();
		gen_care.delete();
		ending = $urandom_range(0, 5);
		for (int i = 0; i < n_entries; i++) begin
			tail_final = (i == n_entries - 1) && (ending <= 1);
			wild = ($urandom_range(0, 3) == 0);
			v = '0;
			if (wild) begin
				push_item(ACT_CHAR, CH_WILD, 1'b0);
				push_item(ACT_CHAR, 8'($urandom_range(1, 255)), tail_final);
			end else begin
				v = pick_byte();
				push_item(ACT_CHAR, hex_char(v[7:4]), 1'b0);
				push_item(ACT_CHAR, hex_char(v[3:0]), tail_final);
				if (!tail_final)
					push_item(ACT_CHAR, ($urandom_range(0, 3) == 0) ?
						8'($urandom_range(1, 255)) : CH_SEPARATOR, 1'b0);
			end
			if (i < DEPTH) begin
				gen_bytes.push_back(v);
				gen_care.push_back(!wild);
			end
		end
		case (ending)
			1: begin
				// characters after the final one are ignored until a clear
				repeat (2) push_item(ACT_CHAR, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end
			2: push_item(ACT_CHAR, CH_NUL, 1'b0);
			3: push_item(ACT_CHAR, CH_WILD, 1'b1);
			4: push_item(ACT_CHAR, hex_char(4'($urandom_range(0, 15))), 1'b1);
			default: ;
		endcase
	endtask

	// region of n_bytes, with the current pattern planted somewhere if asked
	task automatic push_region(input int n_bytes, input bit plant, input bit close);
		int         pos;
		logic [7:0] b;
		pos = -1;
		if (plant && gen_care.size() > 0 && n_bytes >= gen_care.size())
			pos = $urandom_range(0, n_bytes - gen_care.size());
		for (int j = 0; j < n_bytes; j++) begin
			b = pick_byte();
			if (pos >= 0 && j >= pos && j - pos < gen_care.size() && gen_care[j - pos])
				b = gen_bytes[j - pos];
			push_item(ACT_BYTE, b, close && j == n_bytes - 1);
			// pattern swapped in the middle of a scan
			if ($urandom_range(0, 79) == 0)
				push_pattern($urandom_range(0, 3), 1'b1);
			if ($urandom_range(0, 79) == 0)
				push_item(ACT_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
	endtask

	// mostly a well-formed pattern and a few regions, now and then pure noise
	task automatic run_scenario();
		int n_ent;
		int r;
		int len;
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(4, 12))
				push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
		end else begin
			r = $urandom_range(0, 39);
			if (scenario_index == 2 || r == 0)
				n_ent = DEPTH;
			else if (scenario_index == 5 || r == 1)
				n_ent = DEPTH + $urandom_range(1, 4);
			else if (r < 4)
				n_ent = 0;
			else if (r < 12)
				n_ent = $urandom_range(9, 24);
			else
				n_ent = $urandom_range(1, 8);
			push_pattern(n_ent, $urandom_range(0, 7) != 0);
			repeat ($urandom_range(1, 3)) begin
				len = gen_care.size();
				if (len == 0)
					len = $urandom_range(1, 10);
				push_region(len + $urandom_range(0, 10), $urandom_range(0, 4) != 0,
					$urandom_range(0, 5) != 0);
			end
		end
		scenario_index++;
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		int phase_start;
		arst_n             = 1'b0;
		write_en           = 1'b0;
		write_index        = REG_REGION_START;
		write_data         = '0;
		for (int i = 0; i < DEPTH; i++) begin
			window_mem[i] = '0;
			sig_bytes[i]  = '0;
			sig_care[i]   = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// all-ones registers so the reported address wraps
		write_register(REG_REGION_START, '1);
		write_register(REG_RESULT_OFFSET, '1);

		// empty pattern on a one-byte region, then the unused action
		push_item(ACT_BYTE, 8'h00, 1'b1);
		push_item(ACT_UNUSED, 8'hFF, 1'b1);
		// wildcard plus byte FF, final on the second digit, hit at position zero
		push_item(ACT_CLEAR, 8'h00, 1'b0);
		push_item(ACT_CHAR, CH_WILD, 1'b0);
		push_item(ACT_CHAR, 8'h78, 1'b0);
		push_item(ACT_CHAR, CH_UPPER_F, 1'b0);
		push_item(ACT_CHAR, CH_UPPER_F, 1'b1);
		push_item(ACT_BYTE, 8'h00, 1'b0);
		push_item(ACT_BYTE, 8'hFF, 1'b1);
		// lowercase hex stops the parse, pattern stays empty
		push_item(ACT_CLEAR, 8'hFF, 1'b1);
		push_item(ACT_CHAR, CH_LOWER_A, 1'b0);
		push_item(ACT_BYTE, 8'h10, 1'b1);
		// character zero after a wildcard ends the text, later digits ignored
		push_item(ACT_CLEAR, 8'h00, 1'b0);
		push_item(ACT_CHAR, CH_DIGIT_0 + 8'd1, 1'b0);
		push_item(ACT_CHAR, CH_DIGIT_0, 1'b0);
		push_item(ACT_CHAR, CH_SEPARATOR, 1'b0);
		push_item(ACT_CHAR, CH_WILD, 1'b0);
		push_item(ACT_CHAR, CH_NUL, 1'b0);
		push_item(ACT_CHAR, CH_DIGIT_0 + 8'd2, 1'b0);
		push_item(ACT_BYTE, 8'h10, 1'b1);
		// lone first digit as final character adds no entry
		push_item(ACT_CLEAR, 8'h00, 1'b0);
		push_item(ACT_CHAR, CH_DIGIT_9, 1'b1);
		push_item(ACT_BYTE, 8'hFF, 1'b1);
		settle_pipeline();

		// back-pressure: one-wildcard pattern, every byte a region that hits
		write_register(REG_REGION_START, '0);
		write_register(REG_RESULT_OFFSET, '0);
		sender_burst = 1'b1;
		push_item(ACT_CLEAR, 8'h00, 1'b0);
		push_item(ACT_CHAR, CH_WILD, 1'b0);
		push_item(ACT_CHAR, CH_UPPER_A, 1'b1);
		holds_requested++;
		repeat (30) push_item(ACT_BYTE, pick_byte(), 1'b1);
		settle_pipeline();

		// random phases, each with fresh registers and idle behavior
		count_random = 1'b1;
		while (random_items < RANDOM_ITEMS) begin
			settle_pipeline();
			write_register(REG_REGION_START, pick_config(ADDR_W));
			write_register(REG_RESULT_OFFSET, pick_config(OFFSET_W));
			sender_burst   = ($urandom_range(0, 3) == 0);
			receiver_burst = ($urandom_range(0, 3) == 0);
			phase_start = random_items;
			while (random_items - phase_start < PHASE_ITEMS) begin
				run_scenario();
				if ($urandom_range(0, 9) == 0)
					settle_pipeline();
			end
			// registers are only rewritten on a region boundary
			if (region_open)
				push_item(ACT_BYTE, pick_byte(), 1'b1);
		end
		settle_pipeline();

		if (mismatch_count == 0)
			$display("** wildcard_byte_pattern_scanner: PASSED **");
		else
			$display("** wildcard_byte_pattern_scanner: FAILED **");
		$finish;
	end

endmodule
